### rtl/complex_matrix_multiply_top_assert.svh
// ----------------------------------------------------------------------------
// Complex matrix multiplier assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define COMPLEX_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define CMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// Complex matrix multiplier package
// Shared types and constants of the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int CfgW    = 4;
  localparam int CfgIdxW = 2;
  localparam int AccW    = 36;
  localparam int OutIdxW = 3;

  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  typedef logic [CfgW-1:0]            cmm_cfg_t;
  typedef logic [OutIdxW-1:0]         cmm_idx_t;
  typedef logic signed [AccW-1:0]     cmm_acc_t;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NOP     = 2'd3
  } cmm_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } cmm_reg_e;

  // Product selected in each multiply phase of one inner step.
  typedef enum logic [1:0] {
    PH_RR = 2'd0,
    PH_II = 2'd1,
    PH_RI = 2'd2,
    PH_IR = 2'd3
  } cmm_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FLUSH
  } cmm_state_e;

  typedef struct packed {
    logic       mul_en;
    cmm_phase_e phase;
    logic       clear;
  } cmm_mac_ctrl_t;

endpackage

### rtl/complex_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Complex matrix multiplier
// Loads two complex Q8.8 matrices element by element and streams out their
// product in exact Q20.16, one element of C per result.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (in_valid_i, in_stall_o) carries a mode and one complex
// element. Mode 0 appends the element to A and mode 1 to B, both row-major;
// a load into a full store is dropped. Mode 2 starts the product; mode 3 is
// taken and does nothing.
// During a product in_stall_o stays high. For each element of C the single
// shared multiplier forms the four partial products of each inner step in
// turn, and the flush state adds the last of them. A whole product holds the
// block until the last element of C enters the output register.
// Results leave row-major through an output register (out_valid_o,
// out_stall_i), last_o marking the final element. While the receiver stalls,
// the result holds and the sequencer waits before starting the next element.
// After the last element both load pointers return to zero.
// Reset sets all three dimension registers to 8 and the pointers to zero; the
// stores themselves are not cleared. cfg_ready_o stays high, so the user must
// write dimension registers via cfg_valid_i only while no product is running.
// ----------------------------------------------------------------------------
module complex_matrix_multiply_top
  import cmm_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [ELEM_WIDTH-1:0] elem_re_i,
  input  logic signed [ELEM_WIDTH-1:0] elem_im_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OutIdxW-1:0]           row_index_o,
  output logic [OutIdxW-1:0]           col_index_o,
  output logic signed [AccW-1:0]       prod_re_o,
  output logic signed [AccW-1:0]       prod_im_o,
  output logic                         last_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = $clog2(Depth);
  localparam int PtrW  = $clog2(Depth + 1);
  localparam int DimW  = $clog2(MAX_DIM + 1);
  localparam int CntW  = $clog2(MAX_DIM);
  localparam int DataW = 2 * ELEM_WIDTH;

  function automatic logic [DimW-1:0] eff_dim(input cmm_cfg_t d);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(d);
    end
    return r;
  endfunction

  cmm_cfg_t         rows_a_q, inner_q, cols_b_q;
  cmm_state_e       state_q, state_d;
  logic [DimW-1:0]  nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
  logic [CntW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  cmm_phase_e       ph_q, ph_d;
  logic [AddrW-1:0] base_q, base_d, a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic [PtrW-1:0]  a_ptr_q, a_ptr_d, b_ptr_q, b_ptr_d;
  logic             in_acc, out_load, is_last, done;
  logic             we_a, we_b;
  cmm_mode_e        mode;
  cmm_mac_ctrl_t    mac_ctrl;
  logic [DataW-1:0] a_rdata, b_rdata;
  cmm_acc_t         sum_re, sum_im;
  logic             out_vld_q;
  cmm_idx_t         row_q, col_q;
  cmm_acc_t         re_q, im_q;
  logic             last_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign mode        = cmm_mode_e'(mode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CfgReset;
      inner_q  <= CfgReset;
      cols_b_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cmm_reg_e'(cfg_index_i))
        REG_ROWS_A: rows_a_q <= cfg_data_i;
        REG_INNER:  inner_q  <= cfg_data_i;
        REG_COLS_B: cols_b_q <= cfg_data_i;
        default:    rows_a_q <= rows_a_q;
      endcase
    end
  end

  assign we_a = in_acc && (mode == MODE_LOAD_A) && (a_ptr_q < PtrW'(Depth));
  assign we_b = in_acc && (mode == MODE_LOAD_B) && (b_ptr_q < PtrW'(Depth));

  always_comb begin
    a_ptr_d = a_ptr_q;
    b_ptr_d = b_ptr_q;
    if (done) begin
      a_ptr_d = '0;
      b_ptr_d = '0;
    end else begin
      if (we_a) begin
        a_ptr_d = a_ptr_q + PtrW'(1);
      end
      if (we_b) begin
        b_ptr_d = b_ptr_q + PtrW'(1);
      end
    end
  end

  assign is_last  = (DimW'(i_q) == nr_q - DimW'(1)) && (DimW'(j_q) == nc_q - DimW'(1));
  assign out_load = (state_q == ST_FLUSH) && (!out_vld_q || !out_stall_i);
  assign done     = out_load && is_last;

  always_comb begin
    state_d         = state_q;
    nr_d            = nr_q;
    nk_d            = nk_q;
    nc_d            = nc_q;
    i_d             = i_q;
    j_d             = j_q;
    k_d             = k_q;
    ph_d            = ph_q;
    base_d          = base_q;
    a_addr_d        = a_addr_q;
    b_addr_d        = b_addr_q;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.phase  = ph_q;
    mac_ctrl.clear  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_COMPUTE)) begin
          state_d        = ST_MUL;
          nr_d           = eff_dim(rows_a_q);
          nk_d           = eff_dim(inner_q);
          nc_d           = eff_dim(cols_b_q);
          i_d            = '0;
          j_d            = '0;
          k_d            = '0;
          ph_d           = PH_RR;
          base_d         = '0;
          a_addr_d       = '0;
          b_addr_d       = '0;
          mac_ctrl.clear = 1'b1;
        end
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        ph_d = cmm_phase_e'(ph_q + 2'd1);
        if (ph_q == PH_IR) begin
          if (DimW'(k_q) == nk_q - DimW'(1)) begin
            state_d = ST_FLUSH;
          end else begin
            k_d      = k_q + CntW'(1);
            a_addr_d = a_addr_q + AddrW'(1);
            b_addr_d = b_addr_q + AddrW'(nc_q);
          end
        end
      end
      ST_FLUSH: begin
        if (out_load) begin
          mac_ctrl.clear = 1'b1;
          k_d            = '0;
          ph_d           = PH_RR;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MUL;
            if (DimW'(j_q) == nc_q - DimW'(1)) begin
              j_d      = '0;
              i_d      = i_q + CntW'(1);
              base_d   = base_q + AddrW'(nk_q);
              a_addr_d = base_q + AddrW'(nk_q);
              b_addr_d = '0;
            end else begin
              j_d      = j_q + CntW'(1);
              a_addr_d = base_q;
              b_addr_d = AddrW'(j_q) + AddrW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      a_ptr_q   <= '0;
      b_ptr_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_ptr_q <= a_ptr_d;
      b_ptr_q <= b_ptr_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q     <= nr_d;
    nk_q     <= nk_d;
    nc_q     <= nc_d;
    i_q      <= i_d;
    j_q      <= j_d;
    k_q      <= k_d;
    ph_q     <= ph_d;
    base_q   <= base_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    if (out_load) begin
      row_q  <= cmm_idx_t'(i_q);
      col_q  <= cmm_idx_t'(j_q);
      re_q   <= sum_re;
      im_q   <= sum_im;
      last_q <= is_last;
    end
  end

  cmm_mem #(
    .Depth (Depth),
    .Width (DataW)
  ) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (a_ptr_q[AddrW-1:0]),
    .wdata_i ({elem_re_i, elem_im_i}),
    .raddr_i (a_addr_d),
    .rdata_o (a_rdata)
  );

  cmm_mem #(
    .Depth (Depth),
    .Width (DataW)
  ) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (b_ptr_q[AddrW-1:0]),
    .wdata_i ({elem_re_i, elem_im_i}),
    .raddr_i (b_addr_d),
    .rdata_o (b_rdata)
  );

  cmm_mac #(
    .ElemWidth (ELEM_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_data_i (a_rdata),
    .b_data_i (b_rdata),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im)
  );

  assign out_valid_o = out_vld_q;
  assign row_index_o = row_q;
  assign col_index_o = col_q;
  assign prod_re_o   = re_q;
  assign prod_im_o   = im_q;
  assign last_o      = last_q;

  `include "complex_matrix_multiply_top_assert.svh"

  `CMM_ASSERT_IMPL(a_ptr_bound_a, 1'b1, (a_ptr_q <= PtrW'(Depth)) && (b_ptr_q <= PtrW'(Depth)))

  `CMM_ASSERT_IMPL(loop_bound_a, state_q != ST_IDLE,
                   (DimW'(i_q) < nr_q) && (DimW'(j_q) < nc_q) && (DimW'(k_q) < nk_q))

  `CMM_ASSERT_NEXT(finish_idle_a, done,
                   (state_q == ST_IDLE) && (a_ptr_q == '0) && (b_ptr_q == '0) && last_o)

endmodule

### rtl/cmm_mem.sv
// ----------------------------------------------------------------------------
// Complex matrix multiplier element store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module cmm_mem #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cmm_mac.sv
// ----------------------------------------------------------------------------
// Complex matrix multiplier shared multiply-accumulate unit
// One multiplier forms the four partial products of each inner step in turn;
// a registered product is added to the real or imaginary sum, im*im negated.
// ----------------------------------------------------------------------------
module cmm_mac
  import cmm_pkg::*;
#(
  parameter int ElemWidth = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmm_mac_ctrl_t            ctrl_i,
  input  logic [2*ElemWidth-1:0]   a_data_i,
  input  logic [2*ElemWidth-1:0]   b_data_i,
  output cmm_acc_t                 sum_re_o,
  output cmm_acc_t                 sum_im_o
);

  localparam int ProdW = 2 * ElemWidth;

  logic signed [ElemWidth-1:0] a_re, a_im, b_re, b_im;
  logic signed [ElemWidth-1:0] op_a, op_b;
  logic signed [ProdW-1:0]     mul;
  logic signed [ProdW-1:0]     prod_q;
  cmm_phase_e                  prod_ph_q;
  logic                        prod_vld_q;
  cmm_acc_t                    contrib;
  cmm_acc_t                    acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  cmm_acc_t                    sum_re, sum_im;

  assign a_re = $signed(a_data_i[ProdW-1:ElemWidth]);
  assign a_im = $signed(a_data_i[ElemWidth-1:0]);
  assign b_re = $signed(b_data_i[ProdW-1:ElemWidth]);
  assign b_im = $signed(b_data_i[ElemWidth-1:0]);

  always_comb begin
    unique case (ctrl_i.phase)
      PH_RR: begin
        op_a = a_re;
        op_b = b_re;
      end
      PH_II: begin
        op_a = a_im;
        op_b = b_im;
      end
      PH_RI: begin
        op_a = a_re;
        op_b = b_im;
      end
      PH_IR: begin
        op_a = a_im;
        op_b = b_re;
      end
      default: begin
        op_a = a_re;
        op_b = b_re;
      end
    endcase
  end

  assign mul = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul;
    prod_ph_q <= ctrl_i.phase;
  end

  assign contrib = AccW'(prod_q);

  always_comb begin
    sum_re = acc_re_q;
    sum_im = acc_im_q;
    if (prod_vld_q) begin
      unique case (prod_ph_q)
        PH_RR:   sum_re = acc_re_q + contrib;
        PH_II:   sum_re = acc_re_q - contrib;
        PH_RI:   sum_im = acc_im_q + contrib;
        PH_IR:   sum_im = acc_im_q + contrib;
        default: sum_re = acc_re_q;
      endcase
    end
    acc_re_d = ctrl_i.clear ? '0 : sum_re;
    acc_im_d = ctrl_i.clear ? '0 : sum_im;
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  assign sum_re_o = sum_re;
  assign sum_im_o = sum_im;

endmodule
